// ===== rtl/core/smap_pkg.sv =====
// Shared types and constants for the tape sector map lookup block.
package smap_pkg;

    // Command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FIND = 2'd1;
    localparam logic [1:0] CMD_TYPE = 2'd2;

    // File byte markers and sector limits
    localparam logic [7:0] FILE_EMPTY  = 8'hFD;
    localparam logic [7:0] FILE_BAD    = 8'hFF;
    localparam logic [7:0] SECTOR_NONE = 8'd254;
    localparam logic [7:0] SECTOR_MAP  = 8'd0;

    // Sector type codes
    localparam logic [2:0] TYPE_MAP       = 3'd0;
    localparam logic [2:0] TYPE_EMPTY     = 3'd1;
    localparam logic [2:0] TYPE_BAD       = 3'd2;
    localparam logic [2:0] TYPE_FILE      = 3'd3;
    localparam logic [2:0] TYPE_NOT_FOUND = 3'd4;

    localparam int ENTRY_W = 16;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] sector_index;
        logic [7:0] file_number;
        logic [7:0] block_number;
    } smap_in_t;

    typedef struct packed {
        logic       found;
        logic [7:0] found_sector;
        logic [2:0] sector_type;
    } smap_out_t;

endpackage

// ===== rtl/core/smap_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/smap_engine.sv =====
// Command sequencer: map writes, linear find scan and sector classification.
module smap_engine
    import smap_pkg::*;
#(
    parameter int MAP_ENTRIES = 255,
    localparam int AW = $clog2(MAP_ENTRIES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  smap_in_t           cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output smap_out_t          res,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    localparam int LAST_SEC = (MAP_ENTRIES - 1 < 253) ? MAP_ENTRIES - 1 : 253;
    localparam logic [7:0] LAST_W    = 8'(LAST_SEC);
    localparam logic [8:0] ENTRIES_W = 9'(MAP_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TYPE = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [7:0]         pend_reg, pend_next;   // sector whose entry is on rdata
    logic [ENTRY_W-1:0] key_reg, key_next;
    logic [7:0]         sec_reg, sec_next;
    smap_out_t          res_reg, res_next;

    logic       accept;
    logic [7:0] pend_inc;
    logic       sec_in_range;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign pend_inc  = pend_reg + 8'd1;
    assign sec_in_range = ({1'b0, sec_reg} < ENTRIES_W) && (sec_reg < SECTOR_NONE);

    assign ram_we    = accept && (cmd.command == CMD_LOAD)
                       && ({1'b0, cmd.sector_index} < ENTRIES_W);
    assign ram_waddr = cmd.sector_index[AW-1:0];
    assign ram_wdata = {cmd.file_number, cmd.block_number};

    always_comb begin
        ram_raddr = pend_inc[AW-1:0];
        if (state_reg == ST_IDLE) begin
            if (cmd.command == CMD_TYPE) begin
                ram_raddr = cmd.sector_index[AW-1:0];
            end else begin
                ram_raddr = AW'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        key_next   = key_reg;
        sec_next   = sec_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    unique case (cmd.command)
                        CMD_FIND: begin
                            key_next   = {cmd.file_number, cmd.block_number};
                            pend_next  = 8'd1;
                            state_next = ST_SCAN;
                        end
                        CMD_TYPE: begin
                            sec_next   = cmd.sector_index;
                            state_next = ST_TYPE;
                        end
                        default: begin
                            // load and unused code answer with an all-zero transaction
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (ram_rdata == key_reg) begin
                    res_next.found        = 1'b1;
                    res_next.found_sector = pend_reg;
                    state_next            = ST_RESP;
                end else if (pend_reg == LAST_W) begin
                    state_next = ST_RESP;
                end else begin
                    pend_next = pend_inc;
                end
            end
            ST_TYPE: begin
                if (sec_reg == SECTOR_MAP) begin
                    res_next.sector_type = TYPE_MAP;
                end else if (!sec_in_range) begin
                    res_next.sector_type = TYPE_NOT_FOUND;
                end else if (ram_rdata[15:8] == FILE_EMPTY) begin
                    res_next.sector_type = TYPE_EMPTY;
                end else if (ram_rdata[15:8] == FILE_BAD) begin
                    res_next.sector_type = TYPE_BAD;
                end else begin
                    res_next.sector_type = TYPE_FILE;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pend_reg <= pend_next;
        key_reg  <= key_next;
        sec_reg  <= sec_next;
        res_reg  <= res_next;
    end

    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule

// ===== rtl/core/sector_map_lookup.sv =====
// Top level of the tape sector map lookup: map RAM, sequencer and output register.
//
//  port group  dir  handshake          payload
//  s_          in   s_valid/s_ready    s_payload (command, sector_index, file, block)
//  m_          out  m_valid/m_ready    m_payload (found, found_sector, sector_type)
//
// One transaction is worked on at a time. A find reads map entries from sector 1 up,
// at most min(253, MAP_ENTRIES-1) of them, one map RAM read per cycle. A result then
// sits in the output register until taken; the next command is accepted meanwhile.
// aresetn is synchronous; map contents are not cleared and read as undefined
// until loaded. A stalled output holds the sequencer once the register is full.
module sector_map_lookup
    import smap_pkg::*;
#(
    parameter int MAP_ENTRIES = 255
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  smap_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output smap_out_t m_payload
);

    localparam int AW = $clog2(MAP_ENTRIES);

    logic               res_valid;
    logic               res_ready;
    smap_out_t          res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic      m_valid_reg, m_valid_next;
    smap_out_t m_payload_reg, m_payload_next;

    smap_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAP_ENTRIES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smap_engine #(
        .MAP_ENTRIES(MAP_ENTRIES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_payload),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (res_ready) begin
            m_valid_next   = res_valid;
            m_payload_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
